/* rtl/core/longest_prefix_route_table_assert.svh */
// Assertion macros shared by the route table RTL.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define LPRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define LPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lprt_pkg.sv */
// Types and constants of the longest-prefix route table.
`timescale 1ns / 1ps

package lprt_pkg;

   localparam int ENTRIES       = 8;
   localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W         = $clog2(ENTRIES + 1);
   localparam int ENTRY_INDEX_W = 3;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DEL    = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOROUTE = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] network;
      logic [31:0] netmask;
      logic [31:0] next_hop;
      logic [3:0]  interface_id;
      logic        use_filter;
      logic [31:0] dest_addr;
   } req_word_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [3:0]               found_interface;
      logic [31:0]              found_next_hop;
      logic [31:0]              found_netmask;
      logic [ENTRY_INDEX_W-1:0] entry_index;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] network;
      logic [31:0] netmask;
      logic [31:0] gateway;
      logic [3:0]  ifc;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/lprt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/longest_prefix_route_table.sv */
// Top level of the longest-prefix route table: sequencer, valid bits, entry RAM.
//
//   channel   dir   handshake              word
//   req       in    req_valid/req_ready    req_data  (req_word_type)
//   rsp       out   rsp_valid/rsp_ready    rsp_data  (rsp_word_type)
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Add: walks the valid bits one entry a cycle until it finds a free entry or the table ends.
// Delete and lookup: one entry RAM read and one compare a cycle, over every entry.
// Other kinds go straight to the result. The result register frees the input side while a result waits.
// Reset clears all valid bits at once; entry RAM contents are never cleared.
`timescale 1ns / 1ps

module longest_prefix_route_table
   import lprt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_ff, chk_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   req_word_type      req_ff, req_in;
   logic              have_ff, have_in;
   logic              full_ff, full_in;
   logic [31:0]       best_mask_ff, best_mask_in;
   logic [31:0]       best_hop_ff, best_hop_in;
   logic [3:0]        best_ifc_ff, best_ifc_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;

   logic              req_fire;
   logic              cnt_end;
   logic [IDX_W-1:0]  cnt_idx;
   logic              add_hit;
   logic              ram_rd_en;
   entry_type         ram_wr_data;
   entry_type         ent;
   logic              ent_ok;
   logic              del_hit;
   logic              lk_hit;
   logic              rsp_load;
   rsp_word_type      rsp_next;

   lprt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (add_hit),
      .wr_addr (cnt_idx),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_idx),
      .rd_data (ent)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign cnt_end   = (cnt_ff == CNT_W'(ENTRIES));
   assign cnt_idx   = cnt_ff[IDX_W-1:0];

   assign ram_wr_data.network = req_ff.network;
   assign ram_wr_data.netmask = req_ff.netmask;
   assign ram_wr_data.gateway = req_ff.next_hop;
   assign ram_wr_data.ifc     = req_ff.interface_id;

   assign add_hit   = (state_ff == ST_ADD) && !cnt_end && !valid_ff[cnt_idx];
   assign ram_rd_en = (state_ff == ST_SCAN) && !cnt_end;

   // shared compare unit, one entry a cycle
   assign ent_ok  = chk_ff && valid_ff[chk_idx_ff];
   assign del_hit = ent_ok && (req_ff.kind == KIND_DEL) &&
                    (ent.ifc == req_ff.interface_id);
   assign lk_hit  = ent_ok && (req_ff.kind == KIND_LOOKUP) &&
                    ((req_ff.dest_addr & ent.netmask) == ent.network) &&
                    (!req_ff.use_filter || (ent.ifc == req_ff.interface_id)) &&
                    (!have_ff || (best_mask_ff < ent.netmask));

   always_comb begin
      rsp_next = '0;
      rsp_next.status = STATUS_OK;
      unique case (req_ff.kind) inside
         KIND_ADD: begin
            if (full_ff) begin
               rsp_next.status = STATUS_FULL;
            end else begin
               rsp_next.entry_index = ENTRY_INDEX_W'(best_idx_ff);
            end
         end
         KIND_LOOKUP: begin
            if (have_ff) begin
               rsp_next.found_interface = best_ifc_ff;
               rsp_next.found_next_hop  = best_hop_ff;
               rsp_next.found_netmask   = best_mask_ff;
               rsp_next.entry_index     = ENTRY_INDEX_W'(best_idx_ff);
            end else begin
               rsp_next.status = STATUS_NOROUTE;
            end
         end
         default: begin
            rsp_next.status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      valid_in     = valid_ff;
      req_in       = req_ff;
      have_in      = have_ff;
      full_in      = full_ff;
      best_mask_in = best_mask_ff;
      best_hop_in  = best_hop_ff;
      best_ifc_in  = best_ifc_ff;
      best_idx_in  = best_idx_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in      = req_data;
               cnt_in      = '0;
               have_in     = 1'b0;
               full_in     = 1'b0;
               best_idx_in = '0;
               unique case (req_data.kind) inside
                  KIND_ADD:              state_in = ST_ADD;
                  KIND_DEL, KIND_LOOKUP: state_in = ST_SCAN;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD: begin
            if (cnt_end) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else if (add_hit) begin
               valid_in[cnt_idx] = 1'b1;
               best_idx_in       = cnt_idx;
               state_in          = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (!cnt_end) begin
               cnt_in     = cnt_ff + 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = cnt_idx;
            end else if (!chk_ff) begin
               state_in = ST_DONE;
            end
            if (del_hit) begin
               valid_in[chk_idx_ff] = 1'b0;
            end
            if (lk_hit) begin
               have_in      = 1'b1;
               best_mask_in = ent.netmask;
               best_hop_in  = ent.gateway;
               best_ifc_in  = ent.ifc;
               best_idx_in  = chk_idx_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in = rsp_load ? rsp_next : rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      req_ff       <= req_in;
      have_ff      <= have_in;
      full_ff      <= full_in;
      best_mask_ff <= best_mask_in;
      best_hop_ff  <= best_hop_in;
      best_ifc_ff  <= best_ifc_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "longest_prefix_route_table_assert.svh"

   `LPRT_ASSERT_NOW(a_chk_in_scan, chk_ff, state_ff == ST_SCAN, "entry check outside scan")
   `LPRT_ASSERT_NOW(a_cnt_range, state_ff == ST_ADD || state_ff == ST_SCAN, cnt_ff <= CNT_W'(ENTRIES), "scan counter past table")
   `LPRT_ASSERT_NEXT(a_add_sets_valid, add_hit, valid_ff[$past(cnt_idx)], "added entry not marked valid")
   `LPRT_ASSERT_NOW(a_hit_is_valid, state_ff == ST_DONE && req_ff.kind == KIND_LOOKUP && have_ff, valid_ff[best_idx_ff], "lookup picked a free entry")

endmodule
